@@ src/deq_pkg.sv @@
// shared types and constants of the double-ended queue
`default_nettype none

package deq_pkg;

  // storage geometry
  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // operation codes of a request
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SET_FRONT  = 3'd4,
    OP_SET_BACK   = 3'd5
  } op_t;

  // status codes of a result
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SHOW = 2'd2
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

@@ src/deq_ctrl.sv @@
// controller state machine of the double-ended queue
`default_nettype none

module deq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output deq_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);

  deq_pkg::state_t state_r;
  deq_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      deq_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = deq_pkg::S_SHOW;
      end
      deq_pkg::S_SHOW: begin
        out_valid = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = deq_pkg::S_EXEC;
        end else begin
          state_nxt = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/deq_dp.sv @@
// datapath of the double-ended queue: ring store, positions and count
`default_nettype none

module deq_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire deq_pkg::cmd_t                cmd,
  input  wire logic [2:0]                   in_mode,
  input  wire logic signed [31:0]           in_value,
  output logic signed [31:0]                out_popped,
  output logic [1:0]                        out_status,
  output logic [4:0]                        out_fill
);

  localparam logic [deq_pkg::PTR_W-1:0] PTR_LAST = deq_pkg::PTR_W'(deq_pkg::DEPTH - 1);
  localparam logic [deq_pkg::CNT_W-1:0] CNT_FULL = deq_pkg::CNT_W'(deq_pkg::DEPTH);

  logic [deq_pkg::WORD_W-1:0] mem [deq_pkg::DEPTH];

  logic [2:0]                 mode_r;
  logic [deq_pkg::WORD_W-1:0] value_r;
  logic [deq_pkg::PTR_W-1:0]  front_r, back_r;
  logic [deq_pkg::CNT_W-1:0]  held_r;
  logic [deq_pkg::WORD_W-1:0] rd_data_r;
  logic                       pop_ok_r;
  deq_pkg::stat_t             status_r;

  logic [deq_pkg::PTR_W-1:0]  front_prev, front_next, back_prev, back_next;
  logic [deq_pkg::PTR_W-1:0]  front_nxt, back_nxt, wr_addr, rd_addr;
  logic [deq_pkg::CNT_W-1:0]  held_nxt;
  logic                       wr_en, pop_ok;
  logic                       is_full, is_empty;
  deq_pkg::stat_t             status_nxt;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
  end

  // wrapped neighbour positions
  assign front_prev = (front_r == '0) ? PTR_LAST : front_r - 1'b1;
  assign front_next = (front_r == PTR_LAST) ? '0 : front_r + 1'b1;
  assign back_prev  = (back_r == '0) ? PTR_LAST : back_r - 1'b1;
  assign back_next  = (back_r == PTR_LAST) ? '0 : back_r + 1'b1;
  assign is_full    = (held_r == CNT_FULL);
  assign is_empty   = (held_r == '0);

  // operation decode
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    held_nxt   = held_r;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    rd_addr    = front_r;
    pop_ok     = 1'b0;
    status_nxt = deq_pkg::ST_OK;
    unique case (mode_r)
      deq_pkg::OP_PUSH_FRONT: begin
        wr_addr = front_prev;
        if (is_full) begin
          status_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          front_nxt = front_prev;
          held_nxt  = held_r + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        wr_addr = back_r;
        if (is_full) begin
          status_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en    = 1'b1;
          back_nxt = back_next;
          held_nxt = held_r + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        rd_addr = front_r;
        if (is_empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          front_nxt = front_next;
          held_nxt  = held_r - 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        rd_addr = back_prev;
        if (is_empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          pop_ok   = 1'b1;
          back_nxt = back_prev;
          held_nxt = held_r - 1'b1;
        end
      end
      deq_pkg::OP_SET_FRONT: begin
        wr_addr = front_r;
        if (is_empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          wr_en = 1'b1;
        end
      end
      deq_pkg::OP_SET_BACK: begin
        wr_addr = back_prev;
        if (is_empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          wr_en = 1'b1;
        end
      end
      default: begin
        status_nxt = deq_pkg::ST_OK;
      end
    endcase
  end

  // ring store with registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value_r;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // positions, count and result status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      back_r   <= '0;
      held_r   <= '0;
      pop_ok_r <= 1'b0;
      status_r <= deq_pkg::ST_OK;
    end else if (cmd.exec) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      held_r   <= held_nxt;
      pop_ok_r <= pop_ok;
      status_r <= status_nxt;
    end
  end

  // result fields
  assign out_popped = pop_ok_r ? signed'(rd_data_r) : '0;
  assign out_status = status_r;
  assign out_fill   = held_r;

  // consistency of the ring positions
  logic [deq_pkg::PTR_W:0] gap_sum;
  logic [deq_pkg::PTR_W:0] gap_wrap;
  assign gap_sum  = {1'b0, front_r} + (deq_pkg::PTR_W + 1)'(held_r);
  assign gap_wrap = (gap_sum >= (deq_pkg::PTR_W + 1)'(deq_pkg::DEPTH)) ?
                    gap_sum - (deq_pkg::PTR_W + 1)'(deq_pkg::DEPTH) : gap_sum;

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_FULL)
    else $error("count above depth");

  a_ring_gap: assert property (@(posedge clk) disable iff (!rst_n)
    gap_wrap[deq_pkg::PTR_W-1:0] == back_r)
    else $error("front, back and count disagree");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status_nxt == deq_pkg::ST_FULL |=> $stable(held_r) && $stable(front_r))
    else $error("dropped push changed the queue");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok_r |-> status_r == deq_pkg::ST_OK)
    else $error("pop reported with failing status");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status_nxt == deq_pkg::ST_EMPTY |=> held_r == '0 && $stable(back_r))
    else $error("failed request on empty queue changed it");

endmodule

`default_nettype wire

@@ src/double_ended_queue.sv @@
// top level of the double-ended queue
`default_nettype none

// Bounded double-ended queue of 32-bit words held in a 16-entry ring store.
// A request (in_mode, in_value) is taken at a rising edge with start high
// and busy low. Modes: push front, push back, pop front, pop back, overwrite
// front, overwrite back; unused codes do nothing and report ok.
// Every request gives exactly one result (out_popped, out_status, out_fill),
// shown for a single cycle with out_valid high; the receiver cannot stall.
// The result is on the ports in the show state and is taken at the edge that
// ends it. The request is captured at acceptance, then decoded and the store
// written or read in the execute state; the store's registered read port and
// the result registers feed the show state.
// A new request is refused while busy is high and can be taken in the cycle
// its predecessor's result is on the ports.
// A pop on an empty queue, or an overwrite on one, reports empty and leaves
// the queue alone; a push on a full queue reports full and drops the word.
// Reset (rst_n low, synchronous) empties the queue at once; the store itself
// is not cleared and needs no clearing pass.
module double_ended_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic signed [31:0]      out_popped,
  output logic [1:0]              out_status,
  output logic [4:0]              out_fill
);

  deq_pkg::cmd_t cmd;

  // sequencing
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // store and bookkeeping
  deq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_popped (out_popped),
    .out_status (out_status),
    .out_fill   (out_fill)
  );

endmodule

`default_nettype wire

@@ dv/double_ended_queue_checker.sv @@
// request and result monitor of the double-ended queue with its own ring model
module double_ended_queue_checker
  import deq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic signed [31:0] in_value,
  input  wire logic               out_valid,
  input  wire logic signed [31:0] out_popped,
  input  wire logic [1:0]         out_status,
  input  wire logic [4:0]         out_fill,
  output int                      fails,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] popped;
    stat_t             status;
    logic [CNT_W-1:0]  fill;
  } deque_outcome_t;

  // mirror of the queue contents
  logic [WORD_W-1:0] ring [DEPTH];
  logic [PTR_W-1:0]  head_pos;
  logic [PTR_W-1:0]  tail_pos;
  logic [CNT_W-1:0]  count;

  // results owed by the block, oldest first
  deque_outcome_t outcomes_due [$];

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  // apply one request to the mirror and return what the block should show
  function automatic deque_outcome_t deque_apply(input logic [2:0] mode,
                                                 input logic [WORD_W-1:0] word);
    deque_outcome_t res;
    res = '{popped: '0, status: ST_OK, fill: '0};
    case (op_t'(mode))
      OP_PUSH_FRONT: begin
        if (count == CNT_W'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          head_pos       = ring_prev(head_pos);
          ring[head_pos] = word;
          count          = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (count == CNT_W'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          ring[tail_pos] = word;
          tail_pos       = ring_next(tail_pos);
          count          = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = ring[head_pos];
          head_pos   = ring_next(head_pos);
          count      = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          tail_pos   = ring_prev(tail_pos);
          res.popped = ring[tail_pos];
          count      = count - 1'b1;
        end
      end
      OP_SET_FRONT: begin
        if (count == '0) res.status = ST_EMPTY;
        else ring[head_pos] = word;
      end
      OP_SET_BACK: begin
        if (count == '0) res.status = ST_EMPTY;
        else ring[ring_prev(tail_pos)] = word;
      end
      // spare codes leave the queue alone
      default: ;
    endcase
    res.fill = count;
    return res;
  endfunction

  // compare each result with the oldest owed one, then log the new request
  always @(posedge clk) begin
    deque_outcome_t due;
    bit             bad;
    if (!rst_n) begin
      head_pos = '0;
      tail_pos = '0;
      count    = '0;
      outcomes_due.delete();
    end else begin
      if (out_valid) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual popped %h status %0d fill %0d",
                   $time, out_popped, out_status, out_fill);
          fails++;
        end else begin
          due = outcomes_due.pop_front();
          bad = 1'b0;
          if (out_popped !== due.popped) begin
            $display("%0t: popped: expected %h, actual %h", $time, due.popped, out_popped);
            bad = 1'b1;
          end
          if (out_status !== due.status) begin
            $display("%0t: status: expected %0d, actual %0d", $time, due.status, out_status);
            bad = 1'b1;
          end
          if (out_fill !== due.fill) begin
            $display("%0t: fill: expected %0d, actual %0d", $time, due.fill, out_fill);
            bad = 1'b1;
          end
          if (bad) fails++;
        end
      end
      if (start && !busy) outcomes_due.push_back(deque_apply(in_mode, in_value));
    end
    pending <= outcomes_due.size();
  end

endmodule

@@ dv/double_ended_queue_tb.sv @@
// stimulus, clock, reset and verdict for the double-ended queue
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int         RANDOM_ITEMS  = 1820;
  localparam int         CALM_TAIL     = 200;
  localparam int         STALL_LIMIT   = 1000;
  localparam int         SETTLE_CYCLES = 6;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // stream biases for the random part
  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_EVEN  = 2;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               start    = 1'b0;
  logic [2:0]         in_mode  = '0;
  logic signed [31:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_popped;
  logic [1:0]         out_status;
  logic [4:0]         out_fill;
  int                 fails;
  int                 pending;
  int                 stall_cycles = 0;

  double_ended_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_popped (out_popped),
    .out_status (out_status),
    .out_fill   (out_fill)
  );

  double_ended_queue_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_popped (out_popped),
    .out_status (out_status),
    .out_fill   (out_fill),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hold a request until the block takes it
  task automatic issue(input logic [2:0] mode, input logic [31:0] word);
    start    <= 1'b1;
    in_mode  <= mode;
    in_value <= word;
    do @(posedge clk); while (busy);
  endtask

  // sender gap with junk on the payload
  task automatic hold_off(input int cycles);
    start    <= 1'b0;
    in_mode  <= $urandom;
    in_value <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every owed result has been seen
  task automatic await_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [31:0] corner_word(input int idx);
    case (idx)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 9) == 0) return corner_word($urandom_range(0, 3));
    return $urandom;
  endfunction

  // mode mix leaning towards filling, draining or neither
  function automatic logic [2:0] pick_mode(input int bias);
    int r;
    int push_cut;
    int pop_cut;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  begin push_cut = 70; pop_cut = 85; end
      BIAS_DRAIN: begin push_cut = 15; pop_cut = 85; end
      default:    begin push_cut = 40; pop_cut = 80; end
    endcase
    if (r < push_cut) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < pop_cut)  return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    if (r < 95)       return $urandom_range(0, 1) ? OP_SET_BACK : OP_SET_FRONT;
    return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
  endfunction

  // watchdog on cycles where neither side moves a request or a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("double_ended_queue: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int sent;
    int run_len;
    int bias;
    bit calm;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // everything that needs a word on an empty queue, plus a spare code
    issue(OP_POP_FRONT, corner_word(0));
    issue(OP_POP_BACK, corner_word(1));
    issue(OP_SET_FRONT, corner_word(1));
    issue(OP_SET_BACK, corner_word(2));
    issue(MODE_SPARE_LO, $urandom);

    // fill from both ends so the front position wraps
    for (i = 0; i < DEPTH; i++) begin
      issue(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, (i < 4) ? corner_word(i) : $urandom);
    end

    // pushes on a full queue are dropped
    issue(OP_PUSH_FRONT, corner_word(3));
    issue(OP_PUSH_BACK, corner_word(0));

    // overwrite both ends and read them back
    issue(OP_SET_FRONT, corner_word(3));
    issue(OP_SET_BACK, corner_word(1));
    issue(OP_POP_FRONT, $urandom);
    issue(OP_POP_BACK, $urandom);

    // random stretches, each with its own bias and gap policy
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      bias    = $urandom_range(BIAS_FILL, BIAS_EVEN);
      run_len = $urandom_range(8, 60);
      calm    = ($urandom_range(0, 3) == 0);
      for (i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
        if (sent == RANDOM_ITEMS / 2) await_results();
        if (!calm && sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
          hold_off($urandom_range(1, 18));
        end
        issue(pick_mode(bias), pick_word());
        sent++;
      end
    end

    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue.sv
dv/double_ended_queue_checker.sv
dv/double_ended_queue_tb.sv
